// File: hdl/assert_macros.svh
// Assertion macros for the checker file of this block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an implication holds at every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/nrhp_pkg.sv
// Codes, characters and pattern lookups for the caster response header parser.
// No dependencies.
`default_nettype none

package nrhp_pkg;

    // Input word function codes
    localparam logic [1:0] FUNC_CONNECT    = 2'd0;
    localparam logic [1:0] FUNC_BYTE       = 2'd1;
    localparam logic [1:0] FUNC_DISCONNECT = 2'd2;
    localparam logic [1:0] FUNC_STOP       = 2'd3;

    // Session modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_HEADER = 2'd1;
    localparam logic [1:0] MODE_STREAM = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_EOL    = 3'd1;
    localparam logic [2:0] ERR_TABLE     = 3'd2;
    localparam logic [2:0] ERR_REJECTED  = 3'd3;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd4;

    // Blank line tracker states
    localparam logic [2:0] BLANK_NONE   = 3'd0;
    localparam logic [2:0] BLANK_CR     = 3'd1;
    localparam logic [2:0] BLANK_CRLF   = 3'd2;
    localparam logic [2:0] BLANK_CRLFCR = 3'd3;
    localparam logic [2:0] BLANK_LF     = 3'd4;

    // Status line prefix tracker states (1..3 are partial matches)
    localparam logic [2:0] PREFIX_WAIT = 3'd0;
    localparam logic [2:0] PREFIX_HTTP = 3'd4;
    localparam logic [2:0] PREFIX_NONE = 3'd5;

    // Register indexes
    localparam logic REG_USE_HANDSHAKE = 1'b0;
    localparam logic REG_MAX_HEADER    = 1'b1;

    // Characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] OK_LEN    = 2'd3;
    localparam logic [3:0] TABLE_LEN = 4'd11;

    typedef logic [1:0] mode_t;

    // "200"
    function automatic logic [7:0] ok_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = "2";
            2'd1:    ch = "0";
            default: ch = "0";
        endcase
        return ch;
    endfunction

    // "SOURCETABLE"
    function automatic logic [7:0] table_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = "S";
            4'd1:    ch = "O";
            4'd2:    ch = "U";
            4'd3:    ch = "R";
            4'd4:    ch = "C";
            4'd5:    ch = "E";
            4'd6:    ch = "T";
            4'd7:    ch = "A";
            4'd8:    ch = "B";
            4'd9:    ch = "L";
            4'd10:   ch = "E";
            default: ch = "S";
        endcase
        return ch;
    endfunction

    // "HTTP"
    function automatic logic [7:0] http_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = "H";
            2'd1:    ch = "T";
            2'd2:    ch = "T";
            default: ch = "P";
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ntrip_response_header_parser.sv
// Caster response header parser with payload pass-through (top level).
// Depends on nrhp_pkg.
//
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+------------------------------------------
//  in       | sink      | in_valid / in_ready  | func, rx_byte
//  out      | source    | out_valid/out_ready  | payload_valid, payload_byte, total_payload,
//           |           |                      | link_changed, link_up, error_code
//  apb      | slave     | psel/penable/pready  | use_handshake @0x0, max_header_bytes @0x4
//
// Every input word gives exactly one output word, shown in the cycle after acceptance.
// One word is accepted per cycle while in_ready is high: the session state and result
// register update at the same edge, set by the byte matchers and the header count compare
// in front of them. in_ready drops only while a result is held and out_ready is low.
// rst_n clears the session state and the output valid at once; no clearing pass.
`default_nettype none

module ntrip_response_header_parser #(
    parameter int COUNT_BITS = 16,
    parameter int TOTAL_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  rx_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             payload_valid,
    output logic [7:0]       payload_byte,
    output logic [31:0]      total_payload,
    output logic             link_changed,
    output logic             link_up,
    output logic [2:0]       error_code,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import nrhp_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic        use_hs_reg;
    logic [15:0] max_hdr_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            use_hs_reg  <= 1'b1;
            max_hdr_reg <= 16'd8192;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_USE_HANDSHAKE)
            begin
                use_hs_reg <= pwdata[0];
            end
            else
            begin
                max_hdr_reg <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_MAX_HEADER)
        begin
            prdata = {16'd0, max_hdr_reg};
        end
        else
        begin
            prdata = {31'd0, use_hs_reg};
        end
    end

    // ---------------------------------------------------------------
    // Session state
    // ---------------------------------------------------------------
    mode_t                  mode_reg,        mode_next;
    logic                   in_hdr_reg,      in_hdr_next;
    logic [COUNT_BITS-1:0]  hdr_cnt_reg,     hdr_cnt_next;
    logic [2:0]             prefix_reg,      prefix_next;
    logic [1:0]             ok_match_reg,    ok_match_next;
    logic                   ok_seen_reg,     ok_seen_next;
    logic [3:0]             table_match_reg, table_match_next;
    logic                   table_seen_reg,  table_seen_next;
    logic [2:0]             blank_reg,       blank_next;
    logic [TOTAL_BITS-1:0]  total_reg,       total_next;

    // Result register
    logic                   out_valid_reg;
    logic                   pv_reg,  pv_next;
    logic [7:0]             pb_reg,  pb_next;
    logic                   chg_reg, chg_next;
    logic                   up_reg,  up_next;
    logic [2:0]             err_reg, err_next;

    logic accept;

    // Take a new word whenever the result slot is empty or drains this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // ---------------------------------------------------------------
    // Per-byte matchers
    // ---------------------------------------------------------------
    logic       is_lf;
    logic       is_cr;
    logic       is_space;
    logic       blank_hit;
    logic [2:0] blank_step;
    logic [1:0] ok_step;
    logic       ok_seen_step;
    logic [3:0] table_idx;
    logic [3:0] table_step;
    logic       table_seen_step;
    logic [2:0] prefix_step;
    logic       over;

    assign is_lf    = (rx_byte == CH_LF);
    assign is_cr    = (rx_byte == CH_CR);
    assign is_space = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) || is_cr
                   || (rx_byte == CH_VT) || (rx_byte == CH_FF);

    // Limit check uses the count before this byte
    assign over = (32'(hdr_cnt_reg) >= 32'(max_hdr_reg));

    // Blank line: CRLFCRLF, CRLFLF or LFLF, tracked across the whole response
    always_comb begin
        blank_hit  = 1'b0;
        blank_step = BLANK_NONE;
        if (is_lf)
        begin
            if ((blank_reg == BLANK_CRLF) || (blank_reg == BLANK_CRLFCR)
                || (blank_reg == BLANK_LF))
            begin
                blank_hit  = 1'b1;
                blank_step = BLANK_NONE;
            end
            else if (blank_reg == BLANK_CR)
            begin
                blank_step = BLANK_CRLF;
            end
            else
            begin
                blank_step = BLANK_LF;
            end
        end
        else if (is_cr)
        begin
            blank_step = (blank_reg == BLANK_CRLF) ? BLANK_CRLFCR : BLANK_CR;
        end
    end

    // "200" anywhere on the status line
    always_comb begin
        ok_seen_step = ok_seen_reg;
        if (rx_byte == ok_char(ok_match_reg))
        begin
            if (ok_match_reg == OK_LEN - 2'd1)
            begin
                ok_step      = 2'd0;
                ok_seen_step = 1'b1;
            end
            else
            begin
                ok_step = ok_match_reg + 2'd1;
            end
        end
        else
        begin
            ok_step = (rx_byte == ok_char(2'd0)) ? 2'd1 : 2'd0;
        end
    end

    // "SOURCETABLE" anywhere on the status line
    assign table_idx = (table_match_reg < TABLE_LEN) ? table_match_reg : 4'd0;

    always_comb begin
        table_seen_step = table_seen_reg;
        if (rx_byte == table_char(table_idx))
        begin
            if (table_idx == TABLE_LEN - 4'd1)
            begin
                table_step      = 4'd0;
                table_seen_step = 1'b1;
            end
            else
            begin
                table_step = table_idx + 4'd1;
            end
        end
        else
        begin
            table_step = (rx_byte == table_char(4'd0)) ? 4'd1 : 4'd0;
        end
    end

    // "HTTP" at the trimmed start of the status line
    always_comb begin
        prefix_step = prefix_reg;
        if (prefix_reg == PREFIX_WAIT)
        begin
            if (!is_space)
            begin
                prefix_step = (rx_byte == http_char(2'd0)) ? 3'd1 : PREFIX_NONE;
            end
        end
        else if (prefix_reg < PREFIX_HTTP)
        begin
            prefix_step = (rx_byte == http_char(prefix_reg[1:0])) ? prefix_reg + 3'd1
                                                                   : PREFIX_NONE;
        end
    end

    // ---------------------------------------------------------------
    // Word processing
    // ---------------------------------------------------------------
    always_comb begin
        logic do_clear;
        logic go_stream;

        do_clear         = 1'b0;
        go_stream        = 1'b0;
        mode_next        = mode_reg;
        in_hdr_next      = in_hdr_reg;
        hdr_cnt_next     = hdr_cnt_reg;
        prefix_next      = prefix_reg;
        ok_match_next    = ok_match_reg;
        ok_seen_next     = ok_seen_reg;
        table_match_next = table_match_reg;
        table_seen_next  = table_seen_reg;
        blank_next       = blank_reg;
        total_next       = total_reg;
        pv_next          = 1'b0;
        pb_next          = 8'd0;
        chg_next         = 1'b0;
        up_next          = 1'b0;
        err_next         = ERR_NONE;

        unique case (func)
            FUNC_CONNECT:
            begin
                do_clear   = 1'b1;
                total_next = '0;
                if (use_hs_reg)
                begin
                    mode_next = MODE_HEADER;
                end
                else
                begin
                    mode_next = MODE_STREAM;
                    chg_next  = 1'b1;
                    up_next   = 1'b1;
                end
            end
            FUNC_DISCONNECT:
            begin
                // Report link down only when a session was open
                chg_next  = (mode_reg != MODE_IDLE);
                mode_next = MODE_IDLE;
                do_clear  = 1'b1;
            end
            FUNC_STOP:
            begin
                mode_next = MODE_IDLE;
                do_clear  = 1'b1;
            end
            FUNC_BYTE:
            begin
                if (mode_reg == MODE_STREAM)
                begin
                    pv_next = 1'b1;
                    pb_next = rx_byte;
                    if (total_reg != '1)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                end
                else if (mode_reg == MODE_HEADER)
                begin
                    if (hdr_cnt_reg != '1)
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 1'b1;
                    end
                    blank_next = blank_step;

                    if (in_hdr_reg)
                    begin
                        // Blank line on the same byte wins over the limit
                        if (blank_hit)
                        begin
                            go_stream = 1'b1;
                        end
                        else if (over)
                        begin
                            err_next = ERR_TOO_LARGE;
                        end
                    end
                    else if (is_lf)
                    begin
                        if (table_seen_reg)
                        begin
                            err_next = ERR_TABLE;
                        end
                        else if (!ok_seen_reg)
                        begin
                            err_next = ERR_REJECTED;
                        end
                        else if (prefix_reg == PREFIX_HTTP)
                        begin
                            in_hdr_next = 1'b1;
                            if (over)
                            begin
                                err_next = ERR_TOO_LARGE;
                            end
                        end
                        else
                        begin
                            go_stream = 1'b1;
                        end
                    end
                    else
                    begin
                        ok_match_next    = ok_step;
                        ok_seen_next     = ok_seen_step;
                        table_match_next = table_step;
                        table_seen_next  = table_seen_step;
                        prefix_next      = prefix_step;
                        if (over)
                        begin
                            err_next = ERR_NO_EOL;
                        end
                    end

                    if (err_next != ERR_NONE)
                    begin
                        mode_next = MODE_IDLE;
                        do_clear  = 1'b1;
                    end
                    else if (go_stream)
                    begin
                        mode_next = MODE_STREAM;
                        chg_next  = 1'b1;
                        up_next   = 1'b1;
                        do_clear  = 1'b1;
                    end
                end
            end
        endcase

        // Drop all header tracking
        if (do_clear)
        begin
            in_hdr_next      = 1'b0;
            hdr_cnt_next     = '0;
            prefix_next      = PREFIX_WAIT;
            ok_match_next    = 2'd0;
            ok_seen_next     = 1'b0;
            table_match_next = 4'd0;
            table_seen_next  = 1'b0;
            blank_next       = BLANK_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            in_hdr_reg      <= 1'b0;
            hdr_cnt_reg     <= '0;
            prefix_reg      <= PREFIX_WAIT;
            ok_match_reg    <= 2'd0;
            ok_seen_reg     <= 1'b0;
            table_match_reg <= 4'd0;
            table_seen_reg  <= 1'b0;
            blank_reg       <= BLANK_NONE;
            total_reg       <= '0;
        end
        else if (accept)
        begin
            mode_reg        <= mode_next;
            in_hdr_reg      <= in_hdr_next;
            hdr_cnt_reg     <= hdr_cnt_next;
            prefix_reg      <= prefix_next;
            ok_match_reg    <= ok_match_next;
            ok_seen_reg     <= ok_seen_next;
            table_match_reg <= table_match_next;
            table_seen_reg  <= table_seen_next;
            blank_reg       <= blank_next;
            total_reg       <= total_next;
        end
    end

    // ---------------------------------------------------------------
    // Output word register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the payload while stalled; load on every accepted word
    always_ff @(posedge clk) begin
        if (accept)
        begin
            pv_reg  <= pv_next;
            pb_reg  <= pb_next;
            chg_reg <= chg_next;
            up_reg  <= up_next;
            err_reg <= err_next;
        end
    end

    logic [63:0] total_wide;
    logic [31:0] total_out_reg;

    // The count reported is the low 32 bits of the session count
    assign total_wide = 64'(total_next);

    always_ff @(posedge clk) begin
        if (accept)
        begin
            total_out_reg <= total_wide[31:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_valid = pv_reg;
    assign payload_byte  = pb_reg;
    assign total_payload = total_out_reg;
    assign link_changed  = chg_reg;
    assign link_up       = up_reg;
    assign error_code    = err_reg;

endmodule

`default_nettype wire

// File: hdl/nrhp_checker.sv
// Port-level checks for the caster response header parser, with its bind.
// Depends on assert_macros.svh and nrhp_pkg.
`default_nettype none
`include "assert_macros.svh"

module nrhp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        payload_valid,
    input wire logic [7:0]  payload_byte,
    input wire logic [31:0] total_payload,
    input wire logic        link_changed,
    input wire logic        link_up,
    input wire logic [2:0]  error_code
);

    import nrhp_pkg::*;

    `ASSERT_CLK(a_out_hold,
        (out_valid && !out_ready) |=> (out_valid && $stable(payload_byte)
            && $stable(total_payload) && $stable(error_code)),
        "output word changed while stalled")

    `ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output slot")

    `ASSERT_IMPL(a_byte_zero, out_valid && !payload_valid, payload_byte == 8'd0,
        "payload byte set without payload")

    `ASSERT_IMPL(a_up_needs_change, out_valid && link_up, link_changed,
        "link up reported without a change")

    `ASSERT_IMPL(a_error_alone, out_valid && (error_code != ERR_NONE),
        !payload_valid && !link_changed, "error word also carries payload or link change")

endmodule

bind ntrip_response_header_parser nrhp_checker u_nrhp_checker (.*);

`default_nettype wire

// File: verif/ntrip_response_header_parser_tb.sv
// Self-checking testbench for the caster response header parser: drives link and
// byte words, writes both registers over APB, and checks every result word.
// Depends on nrhp_pkg and the ntrip_response_header_parser top level.

module ntrip_response_header_parser_tb;
    import nrhp_pkg::*;

    // One result word, packed in port order so the outputs can be compared at once.
    typedef struct packed {
        logic        pv;
        logic [7:0]  pb;
        logic [31:0] total;
        logic        chg;
        logic        up;
        logic [2:0]  err;
    } parse_result_t;

    // One input word as it waits in the send queue.
    typedef struct packed {
        logic [1:0] f;
        logic [7:0] b;
    } link_word_t;

    // Patterns the status line scanners look for, first character in the top byte.
    localparam logic [87:0] TABLE_TEXT = "SOURCETABLE";
    localparam logic [23:0] OK_TEXT    = "200";
    localparam logic [31:0] HTTP_TEXT  = "HTTP";

    localparam int MAX_REPORTS     = 10;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int PHASE_WORDS     = 300;
    localparam int PHASE_COUNT     = 6;

    // ------------------------------------------------------------------
    // DUT ports, every input driven to a known value from time zero
    // ------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [1:0]  func          = FUNC_STOP;
    logic [7:0]  rx_byte       = 8'h00;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [31:0] total_payload;
    logic        link_changed;
    logic        link_up;
    logic [2:0]  error_code;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    ntrip_response_header_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .total_payload (total_payload),
        .link_changed  (link_changed),
        .link_up       (link_up),
        .error_code    (error_code),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------
    // Parser model: configuration and session state, reset values
    // ------------------------------------------------------------------
    logic        cfg_handshake  = 1'b1;
    logic [15:0] cfg_max_header = 16'd8192;
    mode_t       sess_mode      = MODE_IDLE;
    logic        blk_open       = 1'b0;     // HTTP status accepted, hunting the blank line
    logic [15:0] hdr_count      = '0;
    logic [2:0]  prefix_state   = PREFIX_WAIT;
    logic [1:0]  ok_idx         = '0;
    logic        ok_found       = 1'b0;
    logic [3:0]  table_idx      = '0;
    logic        table_found    = 1'b0;
    logic [2:0]  blank_state    = BLANK_NONE;
    logic [31:0] payload_count  = '0;

    // Testbench bookkeeping
    link_word_t    pending_words[$];     // words not yet offered to the block
    parse_result_t expected_results[$];  // predicted result words, oldest first
    link_word_t    drive_word;
    parse_result_t want;
    parse_result_t got;
    logic          in_taken   = 1'b0;    // input word accepted at the last rising edge
    logic          calm       = 1'b0;    // no random idling on either side
    logic          squeeze    = 1'b0;    // receiver holds off
    logic          squeeze_go = 1'b0;
    int            fault_count = 0;

    // Drop everything learned about the current response header.
    function automatic void clear_scan();
        blk_open     = 1'b0;
        hdr_count    = '0;
        prefix_state = PREFIX_WAIT;
        ok_idx       = '0;
        ok_found     = 1'b0;
        table_idx    = '0;
        table_found  = 1'b0;
        blank_state  = BLANK_NONE;
    endfunction

    // Advance the model by one accepted input word and return the result word it gives.
    function automatic parse_result_t parse_step(input logic [1:0] f, input logic [7:0] c);
        parse_result_t r;
        logic          over;
        logic          blank;
        r = '0;
        case (f)
            FUNC_CONNECT:
            begin
                // Restart the session from any mode; raw mode is up at once.
                clear_scan();
                payload_count = '0;
                if (cfg_handshake)
                    sess_mode = MODE_HEADER;
                else
                begin
                    sess_mode = MODE_STREAM;
                    r.chg = 1'b1;
                    r.up  = 1'b1;
                end
            end
            FUNC_DISCONNECT:
            begin
                // Report link down only when something was running.
                if (sess_mode != MODE_IDLE)
                    r.chg = 1'b1;
                sess_mode = MODE_IDLE;
                clear_scan();
            end
            FUNC_STOP:
            begin
                sess_mode = MODE_IDLE;
                clear_scan();
            end
            default:
            begin
                if (sess_mode == MODE_STREAM)
                begin
                    r.pv = 1'b1;
                    r.pb = c;
                    if (payload_count != '1)
                        payload_count++;
                end
                else if (sess_mode == MODE_HEADER)
                begin
                    // Test the limit against the count before this byte, then count it.
                    over = hdr_count >= cfg_max_header;
                    if (hdr_count != '1)
                        hdr_count++;

                    // Track CRLFCRLF, CRLFLF and LFLF across the whole response.
                    blank = 1'b0;
                    if (c == CH_LF)
                    begin
                        if (blank_state inside {BLANK_CRLF, BLANK_CRLFCR, BLANK_LF})
                        begin
                            blank       = 1'b1;
                            blank_state = BLANK_NONE;
                        end
                        else
                            blank_state = (blank_state == BLANK_CR) ? BLANK_CRLF : BLANK_LF;
                    end
                    else if (c == CH_CR)
                        blank_state = (blank_state == BLANK_CRLF) ? BLANK_CRLFCR : BLANK_CR;
                    else
                        blank_state = BLANK_NONE;

                    if (blk_open)
                    begin
                        // The blank line on the tripping byte still opens the stream.
                        if (blank)
                        begin
                            sess_mode = MODE_STREAM;
                            r.chg     = 1'b1;
                            r.up      = 1'b1;
                        end
                        else if (over)
                            r.err = ERR_TOO_LARGE;
                    end
                    else if (c == CH_LF)
                    begin
                        // Status line done: judge it.
                        if (table_found)
                            r.err = ERR_TABLE;
                        else if (!ok_found)
                            r.err = ERR_REJECTED;
                        else if (prefix_state == PREFIX_HTTP)
                        begin
                            blk_open = 1'b1;
                            if (over)
                                r.err = ERR_TOO_LARGE;
                        end
                        else
                        begin
                            sess_mode = MODE_STREAM;
                            r.chg     = 1'b1;
                            r.up      = 1'b1;
                        end
                    end
                    else
                    begin
                        if (c == OK_TEXT[23 - 8*ok_idx -: 8])
                        begin
                            if (ok_idx == 2'd2)
                            begin
                                ok_found = 1'b1;
                                ok_idx   = '0;
                            end
                            else
                                ok_idx++;
                        end
                        else
                            ok_idx = (c == OK_TEXT[23 -: 8]) ? 2'd1 : 2'd0;

                        if (c == TABLE_TEXT[87 - 8*table_idx -: 8])
                        begin
                            if (table_idx == 4'd10)
                            begin
                                table_found = 1'b1;
                                table_idx   = '0;
                            end
                            else
                                table_idx++;
                        end
                        else
                            table_idx = (c == TABLE_TEXT[87 -: 8]) ? 4'd1 : 4'd0;

                        // Skip leading whitespace, then look for HTTP at the start.
                        if (prefix_state == PREFIX_WAIT)
                        begin
                            if (!(c inside {CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF}))
                                // 1 means the H is matched
                                prefix_state = (c == HTTP_TEXT[31 -: 8]) ? 3'd1 : PREFIX_NONE;
                        end
                        else if (prefix_state < PREFIX_HTTP)
                            prefix_state = (c == HTTP_TEXT[31 - 8*prefix_state -: 8]) ?
                                           prefix_state + 3'd1 : PREFIX_NONE;

                        if (over)
                            r.err = ERR_NO_EOL;
                    end

                    if (r.err != ERR_NONE)
                    begin
                        sess_mode = MODE_IDLE;
                        clear_scan();
                    end
                    else if (sess_mode == MODE_STREAM)
                        clear_scan();
                end
            end
        endcase
        r.total = payload_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_word(input logic [1:0] f, input logic [7:0] b);
        link_word_t w;
        w.f = f;
        w.b = b;
        pending_words.push_back(w);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_word(FUNC_BYTE, s[i]);
    endfunction

    // Random status line character: never LF, biased toward pattern letters.
    function automatic logic [7:0] line_char();
        string      pool = "SOURCETABLEHTP20 \t\r";
        logic [7:0] c;
        if ($urandom_range(3) == 0)
        begin
            c = 8'($urandom);
            return (c == CH_LF) ? CH_SPACE : c;
        end
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    // Queue one caster session: mostly well-formed responses with random
    // content, plus noise and responses cut short.
    task automatic push_session();
        string      status_text;
        string      eol;
        int         kind;
        int         n;
        logic       http_style;
        logic [7:0] ws;
        kind = $urandom_range(9);
        if (kind < 2)
        begin
            // Noise: any function, any byte.
            n = $urandom_range(1, 6);
            repeat (n) push_word(2'($urandom), 8'($urandom));
            return;
        end

        push_word(FUNC_CONNECT, 8'($urandom));
        n = $urandom_range(3);
        repeat (n)
        begin
            case ($urandom_range(4))
                0:       ws = CH_SPACE;
                1:       ws = CH_TAB;
                2:       ws = CH_CR;
                3:       ws = CH_VT;
                default: ws = CH_FF;
            endcase
            push_word(FUNC_BYTE, ws);
        end

        http_style = 1'b0;
        case ($urandom_range(9))
            0, 1:    status_text = "ICY 200 OK";
            2, 3:
            begin
                status_text = "HTTP/1.1 200 OK";
                http_style  = 1'b1;
            end
            4:
            begin
                status_text = "HTTP/1.0 200 OK";
                http_style  = 1'b1;
            end
            5:       status_text = "ICY 401 Unauthorized";
            6:       status_text = "SOURCETABLE 200 OK";
            7:
            begin
                status_text = "HTTP/1.1 404 Not Found";
                http_style  = 1'b1;
            end
            8:
            begin
                status_text = "HTTP 200 SOURCETABLE";
                http_style  = 1'b1;
            end
            default: status_text = "HTT 2000";
        endcase
        for (int i = 0; i < status_text.len(); i++)
            if ($urandom_range(15) == 0)
                status_text[i] = line_char();

        if (kind == 2)
        begin
            // Cut the response short and drop the link.
            n = $urandom_range(status_text.len());
            for (int i = 0; i < n; i++)
                push_word(FUNC_BYTE, status_text[i]);
            push_word($urandom_range(1) ? FUNC_DISCONNECT : FUNC_STOP, 8'($urandom));
            return;
        end

        push_text(status_text);
        if ($urandom_range(1))
            eol = "\r\n";
        else
            eol = "\n";
        push_text(eol);

        if (http_style)
        begin
            n = $urandom_range(2);
            repeat (n)
            begin
                case ($urandom_range(2))
                    0:       push_text("Server: caster");
                    1:       push_text("Content-Type: gnss/data");
                    default: push_text("Cache-Control: no-cache");
                endcase
                push_text(eol);
            end
            // Mostly end the header block in the same line style.
            if ($urandom_range(3) == 0)
                push_text("\n");
            else
                push_text(eol);
        end

        n = $urandom_range(24);
        repeat (n) push_word(FUNC_BYTE, 8'($urandom));

        case ($urandom_range(3))
            0:       push_word(FUNC_DISCONNECT, 8'($urandom));
            1:       push_word(FUNC_STOP, 8'($urandom));
            2:
            begin
                push_word(FUNC_DISCONNECT, 8'($urandom));
                push_word(FUNC_BYTE, 8'($urandom));
            end
            default: ;
        endcase
    endtask

    // APB write: setup cycle, access cycle, register takes the value at the access edge.
    task automatic reg_write(input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_USE_HANDSHAKE)
            cfg_handshake = value[0];
        else
            cfg_max_header = value[15:0];
    endtask

    // Wait until every queued word went in and every predicted word came out.
    // Check at the rising edge, where the driver's queue and in_valid agree.
    task automatic drain();
        @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    function automatic void report_fault(input string what);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t %s: expected pv=%0d byte=%02h total=%0d chg=%0d up=%0d err=%0d",
                     $realtime, what, want.pv, want.pb, want.total, want.chg, want.up,
                     want.err,
                     " got pv=%0d byte=%02h total=%0d chg=%0d up=%0d err=%0d",
                     got.pv, got.pb, got.total, got.chg, got.up, got.err);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: offer the next word at the falling edge. Hold the word while
    // it waits for in_ready, advance once it is taken, idle now and then.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 7))
            begin
                drive_word = pending_words.pop_front();
                func     <= drive_word.f;
                rx_byte  <= drive_word.b;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall at random, or hold off completely while squeezed.
    always @(negedge clk)
    begin
        if (squeeze)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= 7);
    end

    // Back-pressure: hold the receiver off long enough for the block to
    // fill up and drop in_ready while the sender keeps offering words.
    initial
    begin
        wait (squeeze_go);
        @(posedge clk);
        squeeze <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        squeeze <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Check the result
    // word first, then predict from the input word taken at this edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {payload_valid, payload_byte, total_payload, link_changed, link_up,
                       error_code};
                if (expected_results.size() == 0)
                begin
                    want = '0;
                    report_fault("result word with nothing expected");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want)
                        report_fault("result word mismatch");
                end
            end
            in_taken = in_valid && in_ready;
            if (in_taken)
                expected_results.push_back(parse_step(func, rx_byte));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: bytes and link-down while idle are dropped, then an
        // ICY response with CRLF opens the stream; extreme payload bytes.
        push_word(FUNC_BYTE, 8'hFF);
        push_word(FUNC_DISCONNECT, 8'h00);
        push_word(FUNC_STOP, 8'hFF);
        push_word(FUNC_CONNECT, 8'h00);
        push_text("ICY 200\r\n");
        push_word(FUNC_BYTE, 8'h00);
        push_word(FUNC_BYTE, 8'hFF);
        push_word(FUNC_DISCONNECT, 8'h55);
        drain();

        // Raw stream at a one-byte header limit; connect while streaming restarts.
        reg_write(REG_USE_HANDSHAKE, 32'h0000_0000);
        reg_write(REG_MAX_HEADER, 32'h0000_0001);
        @(posedge clk);
        push_word(FUNC_CONNECT, 8'hAA);
        push_word(FUNC_BYTE, 8'h80);
        push_word(FUNC_BYTE, 8'h7F);
        push_word(FUNC_CONNECT, 8'h00);
        push_word(FUNC_STOP, 8'h00);
        drain();

        // Parse with a one-byte limit: the second status byte trips it.
        reg_write(REG_USE_HANDSHAKE, 32'h0000_0001);
        @(posedge clk);
        push_word(FUNC_CONNECT, 8'h00);
        push_text(" H\n");
        drain();

        // Random sessions, one register setting per phase.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:
                begin
                    reg_write(REG_USE_HANDSHAKE, {31'($urandom), 1'b1});
                    reg_write(REG_MAX_HEADER, {16'($urandom), 16'd8192});
                end
                1:
                begin
                    reg_write(REG_USE_HANDSHAKE, 32'h0000_0001);
                    reg_write(REG_MAX_HEADER, 32'($urandom_range(1, 40)));
                end
                2:
                begin
                    reg_write(REG_USE_HANDSHAKE, {31'($urandom), 1'b0});
                    reg_write(REG_MAX_HEADER, 32'hFFFF_FFFF);
                end
                3:
                begin
                    reg_write(REG_USE_HANDSHAKE, 32'hFFFF_FFFF);
                    reg_write(REG_MAX_HEADER, 32'h0000_FFFF);
                end
                4:
                begin
                    reg_write(REG_USE_HANDSHAKE, 32'h0000_0001);
                    reg_write(REG_MAX_HEADER, {16'($urandom), 16'($urandom_range(8, 24))});
                end
                default:
                begin
                    reg_write(REG_USE_HANDSHAKE, 32'($urandom_range(1)));
                    reg_write(REG_MAX_HEADER, 32'($urandom_range(1, 64)));
                end
            endcase
            @(posedge clk);
            // Phase 3 runs without any idling on either side.
            calm <= (p == 3);
            while (pending_words.size() < PHASE_WORDS)
                push_session();
            if (p == 1)
                squeeze_go = 1'b1;
            drain();
        end

        repeat (4) @(posedge clk);
        if (fault_count == 0)
            $display("ntrip_response_header_parser verification clean");
        else
            $display("ntrip_response_header_parser verification failed");
        $finish;
    end

    // Watchdog: a missing result word or a hung handshake ends here.
    initial
    begin
        #1000000;
        $display("ntrip_response_header_parser verification failed");
        $finish;
    end

endmodule
